/* src/dcf_pkg.sv */
// Shared types and character codes for the delimited command framer.
`default_nettype none
package dcf_pkg;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_COLON = 8'h3A;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} dcf_state_t;

endpackage
`default_nettype wire

/* src/delimited_command_framer_core.sv */
// Command framer: buffers received bytes and emits the buffer on a hash.
//
// Channels: rx (rx_valid/rx_ready, rx_byte) takes one received byte per item;
// cmd (cmd_valid/cmd_ready, cmd_byte, cmd_last) gives the buffered command.
// A carriage return is dropped. A colon clears the buffer and the write
// position. A hash emits all CMD_LEN buffer bytes, index 0 first, cmd_last on
// the final one, then clears the buffer. Any other byte is written at the
// write position, which wraps after CMD_LEN-1.
// Ordinary bytes, colons and returns are accepted whenever the block is idle.
// The buffer sits in a one-port memory with a registered read, one entry read
// per cycle straight into the output register while that register is empty or
// cmd_ready is high. The first byte is valid after the hash moves the state to
// emit and the first entry is read; rx_ready stays low until the last is read.
// Clearing is instant: per-entry valid flags are dropped and an entry whose
// flag is low reads as zero.
// Reset drops all valid flags, zeroes the write position and empties the
// output register; the block is ready as soon as reset is released.
// When cmd_ready is low the output register holds its item and no further
// entry is read until it is taken.
`default_nettype none
module delimited_command_framer_core #(
	parameter int CMD_LEN = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       rx_valid,
	output logic            rx_ready,
	input  wire logic [7:0] rx_byte,
	output logic            cmd_valid,
	input  wire logic       cmd_ready,
	output logic [7:0]      cmd_byte,
	output logic            cmd_last
);
	import dcf_pkg::*;

	localparam int PW = (CMD_LEN > 1) ? $clog2(CMD_LEN) : 1;
	localparam logic [PW-1:0] LAST_IDX = PW'(CMD_LEN - 1);

	dcf_state_t state_q, state_d;

	logic [7:0]         mem_q [CMD_LEN];
	logic [CMD_LEN-1:0] vld_q;
	logic [PW-1:0]      pos_q;
	logic [PW-1:0]      idx_q;
	logic [7:0]         rd_data_q;
	logic               rd_vld_q;
	logic               out_valid_q;
	logic               out_last_q;

	logic rx_fire;
	logic is_cr, is_colon, is_hash, is_data;
	logic issue;
	logic clear_all;

	assign rx_fire  = rx_valid && rx_ready;
	assign is_cr    = (rx_byte == CH_CR);
	assign is_colon = (rx_byte == CH_COLON);
	assign is_hash  = (rx_byte == CH_HASH);
	assign is_data  = !is_cr && !is_colon && !is_hash;

	// next state and control
	always_comb begin
		state_d   = state_q;
		rx_ready  = 1'b0;
		issue     = 1'b0;
		clear_all = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				rx_ready = 1'b1;
				if (rx_valid && is_hash) begin
					state_d = ST_EMIT;
				end
				if (rx_valid && is_colon) begin
					clear_all = 1'b1;
				end
			end
			ST_EMIT: begin
				issue = !out_valid_q || cmd_ready;
				if (issue && idx_q == LAST_IDX) begin
					state_d   = ST_IDLE;
					clear_all = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// buffer memory: written only while idle, read only while emitting
	always_ff @(posedge clk) begin
		if (rx_fire && is_data) begin
			mem_q[pos_q] <= rx_byte;
		end
		if (issue) begin
			rd_data_q <= mem_q[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			pos_q       <= '0;
			idx_q       <= '0;
			rd_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (clear_all) begin
				vld_q <= '0;
				pos_q <= '0;
			end else if (rx_fire && is_data) begin
				vld_q[pos_q] <= 1'b1;
				pos_q        <= (pos_q == LAST_IDX) ? '0 : pos_q + 1'b1;
			end

			if (issue) begin
				rd_vld_q    <= vld_q[idx_q];
				out_valid_q <= 1'b1;
				out_last_q  <= (idx_q == LAST_IDX);
				idx_q       <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
			end else if (cmd_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign cmd_valid = out_valid_q;
	assign cmd_byte  = rd_vld_q ? rd_data_q : 8'h00;
	assign cmd_last  = out_last_q;

	// read index only moves during an emit
	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (idx_q == '0))
		else $error("read index nonzero while idle");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && idx_q == LAST_IDX) |=> (vld_q == '0 && pos_q == '0 && state_q == ST_IDLE))
		else $error("buffer not cleared after emit");

	a_colon_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_fire && is_colon) |=> (vld_q == '0 && pos_q == '0))
		else $error("colon did not clear buffer");

	a_data_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_fire && is_data) |=> vld_q[$past(pos_q)])
		else $error("written entry not marked valid");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q <= LAST_IDX) && (idx_q <= LAST_IDX))
		else $error("index out of range");

endmodule
`default_nettype wire

/* tb/delimited_command_framer_core_test.sv */
// Testbench for the delimited command framer: directed and random byte streams checked against a local predictor.
`timescale 1ns / 100ps
module delimited_command_framer_core_test;
	import dcf_pkg::*;

	localparam int CMD_LEN = 8;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} cmd_item_t;

	typedef enum int {
		RDY_ALWAYS,
		RDY_RANDOM,
		RDY_PATTERN
	} rdy_mode_t;

	logic       clk;
	logic       arst_n;
	logic       rx_valid;
	logic       rx_ready;
	logic [7:0] rx_byte;
	logic       cmd_valid;
	logic       cmd_ready;
	logic [7:0] cmd_byte;
	logic       cmd_last;

	// predictor state
	logic [7:0] cmd_image [CMD_LEN];
	int         wr_idx;
	cmd_item_t  pending_cmd_q [$];

	int         err_cnt = 0;
	int         items_sent = 0;
	int         burst_left = 0;
	bit         gaps_on = 1'b1;
	rdy_mode_t  rdy_mode = RDY_ALWAYS;
	int         hold_req = 0;

	delimited_command_framer_core #(
		.CMD_LEN(CMD_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_ready(rx_ready),
		.rx_byte(rx_byte),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd_byte(cmd_byte),
		.cmd_last(cmd_last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	// Receiver: stall pattern per mode, plus long hold-offs on request.
	initial begin
		int hold_left;
		int ph;
		hold_left = 0;
		ph = 0;
		cmd_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			ph++;
			if (hold_left > 0) begin
				hold_left--;
				cmd_ready <= 1'b0;
			end else begin
				case (rdy_mode)
					RDY_ALWAYS: cmd_ready <= 1'b1;
					RDY_RANDOM: cmd_ready <= ($urandom_range(0, 99) < 65);
					default:    cmd_ready <= ((ph % 7) >= 3);
				endcase
			end
		end
	end

	// Updates the command image for one accepted byte; a hash queues the whole buffer.
	function automatic void apply_rx_byte(input logic [7:0] b);
		cmd_item_t it;
		if (b == CH_CR)
			return;
		if (b == CH_HASH) begin
			for (int i = 0; i < CMD_LEN; i++) begin
				it.data = cmd_image[i];
				it.last = (i == CMD_LEN - 1);
				pending_cmd_q.push_back(it);
			end
		end
		if (b == CH_HASH || b == CH_COLON) begin
			for (int i = 0; i < CMD_LEN; i++)
				cmd_image[i] = 8'h00;
			wr_idx = 0;
			return;
		end
		cmd_image[wr_idx] = b;
		wr_idx = (wr_idx + 1) % CMD_LEN;
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		@(negedge clk);
		if (gaps_on && burst_left == 0) begin
			gap = $urandom_range(1, 6);
			rx_valid <= 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		if (burst_left > 0)
			burst_left--;
		rx_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!rx_ready);
		apply_rx_byte(b);
		items_sent++;
	endtask

	task automatic rx_idle();
		@(negedge clk);
		rx_valid <= 1'b0;
	endtask

	task automatic wait_drain();
		rx_idle();
		while (pending_cmd_q.size() != 0)
			@(posedge clk);
		repeat (CMD_LEN + 4) @(posedge clk);
	endtask

	function automatic logic [7:0] rand_plain();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (b == CH_CR || b == CH_HASH || b == CH_COLON);
		return b;
	endfunction

	// Mostly framed commands with random bodies, the rest raw noise.
	task automatic send_random_stream(input int n);
		int stop_at;
		int len;
		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 99) < 80) begin
				if ($urandom_range(0, 99) < 70)
					send_byte(CH_COLON);
				len = $urandom_range(0, 11);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 99) < 10)
						send_byte(CH_CR);
					send_byte(rand_plain());
				end
				send_byte(CH_HASH);
			end else begin
				len = $urandom_range(1, 4);
				for (int i = 0; i < len; i++)
					send_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic test_hash_after_reset();
		send_byte(CH_HASH);
		wait_drain();
	endtask

	task automatic test_store_extremes();
		rdy_mode = RDY_PATTERN;
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h01);
		send_byte(8'h80);
		send_byte(8'h41);
		send_byte(CH_HASH);
		wait_drain();
	endtask

	task automatic test_cr_and_colon();
		rdy_mode = RDY_RANDOM;
		send_byte(8'h78);
		send_byte(8'h79);
		send_byte(CH_CR);
		send_byte(CH_COLON);
		send_byte(8'h7A);
		send_byte(CH_CR);
		send_byte(CH_HASH);
		wait_drain();
	endtask

	task automatic test_overlong_wrap();
		rdy_mode = RDY_ALWAYS;
		for (int i = 0; i < CMD_LEN + 2; i++)
			send_byte(8'(8'h30 + i));
		send_byte(CH_HASH);
		wait_drain();
	endtask

	task automatic test_random_gapped();
		gaps_on = 1'b1;
		rdy_mode = RDY_RANDOM;
		send_random_stream(50);
		wait_drain();
	endtask

	task automatic test_random_smooth();
		gaps_on = 1'b0;
		rdy_mode = RDY_ALWAYS;
		send_random_stream(30);
		wait_drain();
	endtask

	// Receiver holds off while hashes keep coming, so rx_ready has to drop.
	task automatic test_long_stall();
		gaps_on = 1'b0;
		rdy_mode = RDY_PATTERN;
		@(negedge clk);
		hold_req = 80;
		for (int k = 0; k < 3; k++) begin
			send_byte(CH_COLON);
			for (int i = 0; i < 5; i++)
				send_byte(rand_plain());
			send_byte(CH_HASH);
		end
		send_byte(CH_HASH);
		gaps_on = 1'b1;
		rdy_mode = RDY_RANDOM;
		send_random_stream(20);
		wait_drain();
	endtask

	always @(posedge clk) begin
		cmd_item_t e;
		if (arst_n && cmd_valid && cmd_ready) begin
			if (pending_cmd_q.size() == 0) begin
				err_cnt++;
				$display("%0t: unexpected item, expected none, got byte %h last %b",
					$time, cmd_byte, cmd_last);
			end else begin
				e = pending_cmd_q.pop_front();
				if (cmd_byte !== e.data) begin
					err_cnt++;
					$display("%0t: cmd_byte expected %h got %h", $time, e.data, cmd_byte);
				end
				if (cmd_last !== e.last) begin
					err_cnt++;
					$display("%0t: cmd_last expected %b got %b", $time, e.last, cmd_last);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		rx_valid = 1'b0;
		rx_byte = 8'h00;
		for (int i = 0; i < CMD_LEN; i++)
			cmd_image[i] = 8'h00;
		wr_idx = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		test_hash_after_reset();
		test_store_extremes();
		test_cr_and_colon();
		test_overlong_wrap();
		test_random_gapped();
		test_random_smooth();
		test_long_stall();

		if (err_cnt == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

/* sim.f */
src/dcf_pkg.sv
src/delimited_command_framer_core.sv
tb/delimited_command_framer_core_test.sv
